FILE: rtl/rrts_pkg.sv
package rrts_pkg;

    // Thread states held in the thread table.
    localparam logic [2:0] ST_FREE  = 3'd0;
    localparam logic [2:0] ST_READY = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_BLK   = 3'd3;
    localparam logic [2:0] ST_SYNC  = 3'd4;
    localparam logic [2:0] ST_BOTH  = 3'd5;

    // Operation codes.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SPAWN  = 3'd1;
    localparam logic [2:0] OP_TERM   = 3'd2;
    localparam logic [2:0] OP_BLOCK  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_SYNC   = 3'd5;
    localparam logic [2:0] OP_QUERY  = 3'd6;

    // Result status codes.
    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_ERR      = 2'd1;
    localparam logic [1:0] RS_SHUTDOWN = 2'd2;

    localparam logic [30:0] CNT_MAX  = 31'h7FFF_FFFF;
    localparam logic [23:0] TICK_MAX = 24'hFF_FFFF;

    // One thread table entry.
    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] quanta;
        logic [63:0] entry;
        logic [6:0]  wtarget;
        logic [31:0] worder;
    } rrts_word_t;

endpackage

FILE: rtl/rrts_table.sv
module rrts_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic               clk,
    input  logic [AW-1:0]      raddr,
    output rrts_pkg::rrts_word_t rdata,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  rrts_pkg::rrts_word_t wdata
);
    import rrts_pkg::*;

    rrts_word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/rrts_queue.sv
module rrts_queue #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata
);

    logic [AW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler.
// Commands arrive as beats on the s_axis channel (opcode in tuser, thread id and
// entry address in tdata); each command yields exactly one result beat on m_axis.
// The quantum length is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
// The thread table and the ready queue each sit in a single-port-read memory, and
// a sequencer reads, modifies and writes them back one entry per step, so the
// work a command does varies: a query, a plain tick or an error goes straight to
// the result, a spawn scans the table for a free slot, a removal from the ready
// queue shifts the entries behind it, and waking waiters scans the whole table
// again for each waiter woken. After reset, and after thread 0 is terminated, a
// clearing pass rewrites the thread table; no command is accepted during it.
// After reset thread 0 runs alone with one quantum counted.
// The result is held in an output register; a new command is accepted while it
// waits, but a finished result waits for the receiver before the next command
// completes, so a stalled receiver simply holds the block.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // thread_id[6:0], entry_address[70:7], zero pad[71]
    input  logic [71:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], value[32:2], running_thread[39:33], total_quanta[70:40],
    // switched[71], run_entry[135:72], first_run[136], zero pad[143:137]
    output logic [143:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [23:0]  cfg_wdata
);
    import rrts_pkg::*;

    localparam int IW = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] NUM = CW'(MAX_THREADS);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_RD_T   = 5'd2;
    localparam logic [4:0] S_CHK    = 5'd3;
    localparam logic [4:0] S_DISP   = 5'd4;
    localparam logic [4:0] S_RM_RD  = 5'd5;
    localparam logic [4:0] S_RM_CHK = 5'd6;
    localparam logic [4:0] S_REL_RD = 5'd7;
    localparam logic [4:0] S_REL_CK = 5'd8;
    localparam logic [4:0] S_REL_WR = 5'd9;
    localparam logic [4:0] S_PUSH   = 5'd10;
    localparam logic [4:0] S_WR_RD  = 5'd11;
    localparam logic [4:0] S_WR_WR  = 5'd12;
    localparam logic [4:0] S_ST_RD  = 5'd13;
    localparam logic [4:0] S_ST_WR  = 5'd14;
    localparam logic [4:0] S_SP_RD  = 5'd15;
    localparam logic [4:0] S_SP_CHK = 5'd16;
    localparam logic [4:0] S_OUT_RD = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    // Steps of a command program.
    localparam logic [2:0] U_END   = 3'd0;
    localparam logic [2:0] U_NOP   = 3'd1;
    localparam logic [2:0] U_RMH   = 3'd2;
    localparam logic [2:0] U_RMT   = 3'd3;
    localparam logic [2:0] U_REL   = 3'd4;
    localparam logic [2:0] U_WR    = 3'd5;
    localparam logic [2:0] U_PUSH  = 3'd6;
    localparam logic [2:0] U_START = 3'd7;

    localparam logic [1:0] TS_CUR  = 2'd0;
    localparam logic [1:0] TS_TID  = 2'd1;
    localparam logic [1:0] TS_FREE = 2'd2;

    localparam logic [1:0] WK_PLAIN = 2'd0;
    localparam logic [1:0] WK_WAIT  = 2'd1;
    localparam logic [1:0] WK_NEW   = 2'd2;

    logic [4:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [6:0]    tid_reg, tid_next;
    logic [63:0]   entry_reg, entry_next;
    logic [2:0]    ts_reg, ts_next;
    logic          is_cur_reg, is_cur_next;
    logic          sw_reg, sw_next;
    logic [1:0]    status_reg, status_next;
    logic [30:0]   value_reg, value_next;
    logic [2:0]    step_reg, step_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [31:0]   seq_reg, seq_next;
    logic [30:0]   total_reg, total_next;
    logic [23:0]   tick_reg, tick_next;
    logic [23:0]   qlen_reg, qlen_next;
    rrts_word_t    best_reg, best_next;
    logic [IW-1:0] bidx_reg, bidx_next;
    logic [31:0]   bage_reg, bage_next;
    logic [IW-1:0] mt_reg, mt_next;
    logic [2:0]    wst_reg, wst_next;
    logic [1:0]    wkind_reg, wkind_next;
    logic          term0_reg, term0_next;
    logic          mvalid_reg, mvalid_next;
    logic [143:0]  mdata_reg, mdata_next;

    logic [IW-1:0] t_raddr, t_waddr;
    rrts_word_t    t_rdata, t_wdata;
    logic          t_we;
    logic [IW-1:0] q_raddr, q_waddr, q_wdata, q_rdata;
    logic          q_we;

    logic [2:0]    uop;
    logic [1:0]    usel;
    logic [2:0]    ust;
    logic [1:0]    ukind;

    logic [IW-1:0] tid_idx;
    logic          tid_in;
    logic          tid_ok;
    logic [IW-1:0] sel_idx;
    logic [23:0]   tick_inc;
    logic [31:0]   age;
    logic          match;
    rrts_word_t    w;

    rrts_table #(.DEPTH(MAX_THREADS), .AW(IW)) u_table (
        .clk   (clk),
        .raddr (t_raddr),
        .rdata (t_rdata),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata)
    );

    rrts_queue #(.DEPTH(MAX_THREADS), .AW(IW)) u_queue (
        .clk   (clk),
        .raddr (q_raddr),
        .rdata (q_rdata),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata)
    );

    assign tid_idx = IW'(tid_reg);
    assign tid_in  = {25'd0, tid_reg} < 32'(MAX_THREADS);
    assign tid_ok  = tid_in && (t_rdata.status != ST_FREE);
    assign tick_inc = (tick_reg < TICK_MAX) ? tick_reg + 24'd1 : tick_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    // Program of each command, one step at a time.
    always_comb
    begin
        uop   = U_END;
        usel  = TS_TID;
        ust   = ST_FREE;
        ukind = WK_PLAIN;
        case (op_reg)
            OP_TICK:
            begin
                usel = TS_CUR;
                case (step_reg)
                    3'd0: uop = U_RMH;
                    3'd1: uop = U_REL;
                    3'd2:
                    begin
                        uop = U_WR;
                        ust = ST_READY;
                    end
                    3'd3: uop = U_PUSH;
                    3'd4: uop = U_START;
                    default: uop = U_END;
                endcase
            end
            OP_SPAWN:
            begin
                usel = TS_FREE;
                case (step_reg)
                    3'd0:
                    begin
                        uop   = U_WR;
                        ust   = ST_READY;
                        ukind = WK_NEW;
                    end
                    3'd1: uop = U_PUSH;
                    default: uop = U_END;
                endcase
            end
            OP_TERM:
            begin
                case (step_reg)
                    3'd0: uop = U_REL;
                    3'd1:
                    begin
                        if (is_cur_reg)
                        begin
                            uop = U_RMH;
                        end
                        else if (ts_reg == ST_READY)
                        begin
                            uop = U_RMT;
                        end
                        else
                        begin
                            uop = U_NOP;
                        end
                    end
                    3'd2:
                    begin
                        uop = U_WR;
                        ust = ST_FREE;
                    end
                    3'd3: uop = is_cur_reg ? U_START : U_END;
                    default: uop = U_END;
                endcase
            end
            OP_BLOCK:
            begin
                case (ts_reg)
                    ST_RUN:
                    begin
                        case (step_reg)
                            3'd0: uop = U_RMH;
                            3'd1:
                            begin
                                uop = U_WR;
                                ust = ST_BLK;
                            end
                            3'd2: uop = U_START;
                            3'd3: uop = U_REL;
                            default: uop = U_END;
                        endcase
                    end
                    ST_READY:
                    begin
                        case (step_reg)
                            3'd0: uop = U_RMT;
                            3'd1:
                            begin
                                uop = U_WR;
                                ust = ST_BLK;
                            end
                            default: uop = U_END;
                        endcase
                    end
                    ST_SYNC:
                    begin
                        if (step_reg == 3'd0)
                        begin
                            uop = U_WR;
                            ust = ST_BOTH;
                        end
                    end
                    default: uop = U_END;
                endcase
            end
            OP_RESUME:
            begin
                case (ts_reg)
                    ST_BLK:
                    begin
                        case (step_reg)
                            3'd0:
                            begin
                                uop = U_WR;
                                ust = ST_READY;
                            end
                            3'd1: uop = U_PUSH;
                            default: uop = U_END;
                        endcase
                    end
                    ST_BOTH:
                    begin
                        if (step_reg == 3'd0)
                        begin
                            uop = U_WR;
                            ust = ST_SYNC;
                        end
                    end
                    default: uop = U_END;
                endcase
            end
            OP_SYNC:
            begin
                usel = TS_CUR;
                case (step_reg)
                    3'd0: uop = U_RMH;
                    3'd1:
                    begin
                        uop   = U_WR;
                        ust   = ST_SYNC;
                        ukind = WK_WAIT;
                    end
                    3'd2: uop = U_REL;
                    3'd3: uop = U_START;
                    default: uop = U_END;
                endcase
            end
            default: uop = U_END;
        endcase
    end

    always_comb
    begin
        case (usel)
            TS_CUR:  sel_idx = cur_reg;
            TS_FREE: sel_idx = free_reg;
            default: sel_idx = tid_idx;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        tid_next    = tid_reg;
        entry_next  = entry_reg;
        ts_next     = ts_reg;
        is_cur_next = is_cur_reg;
        sw_next     = sw_reg;
        status_next = status_reg;
        value_next  = value_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        free_next   = free_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        seq_next    = seq_reg;
        total_next  = total_reg;
        tick_next   = tick_reg;
        qlen_next   = cfg_we ? cfg_wdata : qlen_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        bage_next   = bage_reg;
        mt_next     = mt_reg;
        wst_next    = wst_reg;
        wkind_next  = wkind_reg;
        term0_next  = term0_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        mdata_next  = mdata_reg;

        t_raddr = head_reg;
        t_we    = 1'b0;
        t_waddr = head_reg;
        t_wdata = t_rdata;
        q_raddr = '0;
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;

        w     = t_rdata;
        age   = t_rdata.worder - seq_reg;
        match = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                t_we    = 1'b1;
                t_waddr = idx_reg[IW-1:0];
                t_wdata = '0;
                if (idx_reg == '0)
                begin
                    t_wdata.status = ST_RUN;
                    t_wdata.quanta = 31'd1;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = '0;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == NUM - 1'b1)
                begin
                    state_next = term0_reg ? S_OUT_RD : S_IDLE;
                    term0_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    tid_next    = s_axis_tdata[6:0];
                    entry_next  = s_axis_tdata[70:7];
                    cur_next    = head_reg;
                    status_next = RS_OK;
                    value_next  = '0;
                    sw_next     = 1'b0;
                    step_next   = '0;
                    state_next  = S_RD_T;
                end
            end
            S_RD_T:
            begin
                t_raddr    = tid_in ? tid_idx : '0;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                ts_next    = t_rdata.status;
                state_next = S_OUT_RD;
                case (op_reg)
                    OP_TICK:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= qlen_reg)
                        begin
                            sw_next    = 1'b1;
                            state_next = S_DISP;
                        end
                    end
                    OP_SPAWN:
                    begin
                        idx_next   = '0;
                        state_next = S_SP_RD;
                    end
                    OP_TERM:
                    begin
                        if (tid_reg == 7'd0)
                        begin
                            // Thread 0 gone: the whole scheduler starts over.
                            status_next = RS_SHUTDOWN;
                            sw_next     = 1'b1;
                            count_next  = CW'(1);
                            head_next   = '0;
                            seq_next    = '0;
                            total_next  = 31'd1;
                            tick_next   = '0;
                            idx_next    = '0;
                            term0_next  = 1'b1;
                            state_next  = S_INIT;
                        end
                        else if (!tid_ok)
                        begin
                            status_next = RS_ERR;
                        end
                        else
                        begin
                            is_cur_next = (tid_idx == cur_reg);
                            sw_next     = (tid_idx == cur_reg);
                            state_next  = S_DISP;
                        end
                    end
                    OP_BLOCK:
                    begin
                        if (tid_reg == 7'd0 || !tid_ok)
                        begin
                            status_next = RS_ERR;
                        end
                        else
                        begin
                            sw_next    = (t_rdata.status == ST_RUN);
                            state_next = S_DISP;
                        end
                    end
                    OP_RESUME:
                    begin
                        if (!tid_ok)
                        begin
                            status_next = RS_ERR;
                        end
                        else
                        begin
                            state_next = S_DISP;
                        end
                    end
                    OP_SYNC:
                    begin
                        if (cur_reg == '0 || !tid_ok || tid_idx == cur_reg)
                        begin
                            status_next = RS_ERR;
                        end
                        else
                        begin
                            sw_next    = 1'b1;
                            state_next = S_DISP;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!tid_ok)
                        begin
                            status_next = RS_ERR;
                        end
                        else
                        begin
                            value_next = t_rdata.quanta;
                        end
                    end
                    default: status_next = RS_ERR;
                endcase
            end
            S_DISP:
            begin
                mt_next    = sel_idx;
                wst_next   = ust;
                wkind_next = ukind;
                case (uop)
                    U_NOP:
                    begin
                        step_next = step_reg + 3'd1;
                    end
                    U_RMH:
                    begin
                        idx_next   = CW'(1);
                        found_next = 1'b1;
                        state_next = S_RM_RD;
                    end
                    U_RMT:
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = S_RM_RD;
                    end
                    U_REL:
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = S_REL_RD;
                    end
                    U_WR:    state_next = S_WR_RD;
                    U_PUSH:  state_next = S_PUSH;
                    U_START: state_next = S_ST_RD;
                    default:
                    begin
                        if (op_reg == OP_SPAWN)
                        begin
                            value_next = 31'(free_reg);
                        end
                        state_next = S_OUT_RD;
                    end
                endcase
            end
            S_RM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    step_next  = step_reg + 3'd1;
                    state_next = S_DISP;
                end
                else
                begin
                    q_raddr    = idx_reg[IW-1:0];
                    state_next = S_RM_CHK;
                end
            end
            S_RM_CHK:
            begin
                // Once the entry is found, every later entry moves down one place.
                if (found_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = IW'(idx_reg - 1'b1);
                    q_wdata = q_rdata;
                    if (idx_reg == CW'(1))
                    begin
                        head_next = q_rdata;
                    end
                end
                else if (q_rdata == mt_reg)
                begin
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_RM_RD;
            end
            S_PUSH:
            begin
                if (count_reg < NUM)
                begin
                    q_we    = 1'b1;
                    q_waddr = count_reg[IW-1:0];
                    q_wdata = mt_reg;
                    if (count_reg == '0)
                    begin
                        head_next = mt_reg;
                    end
                    count_next = count_reg + 1'b1;
                end
                step_next  = step_reg + 3'd1;
                state_next = S_DISP;
            end
            S_REL_RD:
            begin
                if (idx_reg == NUM)
                begin
                    if (found_reg)
                    begin
                        state_next = S_REL_WR;
                    end
                    else
                    begin
                        step_next  = step_reg + 3'd1;
                        state_next = S_DISP;
                    end
                end
                else
                begin
                    t_raddr    = idx_reg[IW-1:0];
                    state_next = S_REL_CK;
                end
            end
            S_REL_CK:
            begin
                // Oldest waiter on the target wins this pass.
                match = (t_rdata.status inside {ST_SYNC, ST_BOTH}) &&
                        ({25'd0, t_rdata.wtarget} == 32'(mt_reg));
                if (match && (!found_reg || age < bage_reg))
                begin
                    found_next = 1'b1;
                    best_next  = t_rdata;
                    bidx_next  = idx_reg[IW-1:0];
                    bage_next  = age;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_REL_RD;
            end
            S_REL_WR:
            begin
                w       = best_reg;
                t_we    = 1'b1;
                t_waddr = bidx_reg;
                if (best_reg.status == ST_SYNC)
                begin
                    w.status = ST_READY;
                    if (count_reg < NUM)
                    begin
                        q_we    = 1'b1;
                        q_waddr = count_reg[IW-1:0];
                        q_wdata = bidx_reg;
                        if (count_reg == '0)
                        begin
                            head_next = bidx_reg;
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    w.status = ST_BLK;
                end
                t_wdata    = w;
                found_next = 1'b0;
                idx_next   = '0;
                state_next = S_REL_RD;
            end
            S_WR_RD:
            begin
                t_raddr    = mt_reg;
                state_next = S_WR_WR;
            end
            S_WR_WR:
            begin
                w.status = wst_reg;
                if (wkind_reg == WK_WAIT)
                begin
                    w.wtarget = tid_reg;
                    w.worder  = seq_reg;
                    seq_next  = seq_reg + 32'd1;
                end
                else if (wkind_reg == WK_NEW)
                begin
                    w.entry  = entry_reg;
                    w.quanta = '0;
                end
                t_we       = 1'b1;
                t_waddr    = mt_reg;
                t_wdata    = w;
                step_next  = step_reg + 3'd1;
                state_next = S_DISP;
            end
            S_ST_RD:
            begin
                t_raddr    = head_reg;
                state_next = S_ST_WR;
            end
            S_ST_WR:
            begin
                if (t_rdata.quanta != CNT_MAX)
                begin
                    w.quanta = t_rdata.quanta + 31'd1;
                end
                w.status = ST_RUN;
                t_we     = 1'b1;
                t_waddr  = head_reg;
                t_wdata  = w;
                if (total_reg != CNT_MAX)
                begin
                    total_next = total_reg + 31'd1;
                end
                tick_next  = '0;
                step_next  = step_reg + 3'd1;
                state_next = S_DISP;
            end
            S_SP_RD:
            begin
                if (idx_reg == NUM)
                begin
                    status_next = RS_ERR;
                    state_next  = S_OUT_RD;
                end
                else
                begin
                    t_raddr    = idx_reg[IW-1:0];
                    state_next = S_SP_CHK;
                end
            end
            S_SP_CHK:
            begin
                if (t_rdata.status == ST_FREE)
                begin
                    free_next  = idx_reg[IW-1:0];
                    step_next  = '0;
                    state_next = S_DISP;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SP_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // The read of the running thread's entry repeats while we wait.
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, (t_rdata.quanta == 31'd1), t_rdata.entry,
                                   sw_reg, total_reg, 7'(head_reg), value_reg,
                                   status_reg};
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            op_reg     <= '0;
            tid_reg    <= '0;
            ts_reg     <= '0;
            is_cur_reg <= 1'b0;
            sw_reg     <= 1'b0;
            status_reg <= '0;
            value_reg  <= '0;
            step_reg   <= '0;
            cur_reg    <= '0;
            free_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= CW'(1);
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            seq_reg    <= '0;
            total_reg  <= 31'd1;
            tick_reg   <= '0;
            qlen_reg   <= 24'd10000;
            bidx_reg   <= '0;
            bage_reg   <= '0;
            mt_reg     <= '0;
            wst_reg    <= '0;
            wkind_reg  <= '0;
            term0_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            tid_reg    <= tid_next;
            ts_reg     <= ts_next;
            is_cur_reg <= is_cur_next;
            sw_reg     <= sw_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            step_reg   <= step_next;
            cur_reg    <= cur_next;
            free_reg   <= free_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            seq_reg    <= seq_next;
            total_reg  <= total_next;
            tick_reg   <= tick_next;
            qlen_reg   <= qlen_next;
            bidx_reg   <= bidx_next;
            bage_reg   <= bage_next;
            mt_reg     <= mt_next;
            wst_reg    <= wst_next;
            wkind_reg  <= wkind_next;
            term0_reg  <= term0_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        best_reg  <= best_next;
        mdata_reg <= mdata_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg != '0 && count_reg <= NUM))
        else $error("ready queue count out of range while idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_RD_T))
        else $error("accepted command did not start");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the result state");
`endif

endmodule
